### src/pnorm_pkg.sv
// Shared types and constants for the path normalizer.
// Holds the beat structs of both channels, character and mode codes and buffer sizing.
// No dependencies.
`default_nettype none

package pnorm_pkg;

	// Result buffer size and the widths that follow from it.
	localparam int BUF_BYTES = 4096;
	localparam int AW        = $clog2(BUF_BYTES);
	localparam int LW        = AW + 1;
	localparam int LW1       = LW + 1;

	// Largest value the result length field can show.
	localparam int RLEN_MAX = 4095;

	// Item modes.
	localparam logic [1:0] MODE_CWD  = 2'd0;
	localparam logic [1:0] MODE_USER = 2'd1;
	localparam logic [1:0] MODE_READ = 2'd2;

	// Status codes.
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_OVERFLOW = 2'd1;
	localparam logic [1:0] STAT_NOT_ABS = 2'd2;

	// Characters.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  char_in;
		logic [11:0] read_index;
	} item_t;

	typedef struct packed {
		logic        done_res;
		logic [1:0]  status;
		logic [11:0] result_len;
		logic [7:0]  read_char;
	} result_t;

endpackage

`default_nettype wire

### src/path_normalizer_core.sv
// Path normalizer top level: builds a canonical absolute path in an on-chip byte buffer.
// Depends on pnorm_pkg for the beat structs, codes and buffer size.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+---------------------------
//   item     | in        | item_valid/item_stall     | mode, char_in, read_index
//   result   | out       | result_valid/result_stall | done_res, status,
//            |           |                           | result_len, read_char
//
// Each beat is decoded in the idle state, where it touches the buffer, and the result
// register is loaded from the finish state. A segment byte that also needs a separator
// first passes the second-write state, as the buffer has a single write port. A ".."
// segment walks back byte by byte (read, compare); at the root the read state ends it.
// Reset clears all control state but not the buffer; reads past the length show zero.
// A stalled result holds its register, and the item side stalls until it is taken.
`default_nettype none

module path_normalizer_core (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    item_valid,
	output logic                   item_stall,
	input  pnorm_pkg::item_t       item,
	output logic                   result_valid,
	input  wire                    result_stall,
	output pnorm_pkg::result_t     result
);

	import pnorm_pkg::*;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WR2,
		ST_POP_RD,
		ST_POP_CHK,
		ST_FIN
	} seq_t;

	// Job phases: waiting for the working directory, first user byte, rest of the
	// user path, and finished.
	typedef enum logic [1:0] {
		PH_CWD,
		PH_FIRST,
		PH_USER,
		PH_DONE
	} phase_t;

	seq_t    st_q, st_d;
	phase_t  ph_q, ph_d;

	logic [LW-1:0] wl_q, wl_d;          // committed result length
	logic [LW-1:0] seg_len_q, seg_len_d;
	logic [LW-1:0] seg_start_q, seg_start_d;
	logic          dots_q, dots_d;      // current segment holds only dots
	logic [1:0]    err_q, err_d;
	logic          cwd_slash_q, cwd_slash_d;  // working directory starts with a slash
	logic [LW-1:0] cwd_trim_q, cwd_trim_d;    // directory length without trailing slashes
	logic          done_q, done_d;
	logic          hit_q, hit_d;

	// Second write of a new segment, held for the second-write state.
	logic          pend_we_q, pend_we_d;
	logic [AW-1:0] pend_addr_q, pend_addr_d;
	logic [7:0]    pend_char_q, pend_char_d;

	logic          result_valid_d;
	result_t       result_d;

	// Buffer ports.
	logic [7:0]    mem [BUF_BYTES];
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    rdata_q;

	// Scratch values for the decode.
	logic          accept;
	logic          run_user;
	logic          new_seg;
	logic          dots_n;
	logic [LW-1:0] w;
	logic [LW-1:0] wl_eff;
	logic [LW-1:0] start;
	logic [LW1-1:0] pos;
	logic [LW1-1:0] seg_end;
	logic [7:0]    c;

	assign item_stall = (st_q != ST_IDLE) || (result_valid && result_stall);
	assign accept     = item_valid && !item_stall;

	// The buffer: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	always_comb begin
		st_d           = st_q;
		ph_d           = ph_q;
		wl_d           = wl_q;
		seg_len_d      = seg_len_q;
		seg_start_d    = seg_start_q;
		dots_d         = dots_q;
		err_d          = err_q;
		cwd_slash_d    = cwd_slash_q;
		cwd_trim_d     = cwd_trim_q;
		done_d         = done_q;
		hit_d          = hit_q;
		pend_we_d      = pend_we_q;
		pend_addr_d    = pend_addr_q;
		pend_char_d    = pend_char_q;
		result_d       = result;
		result_valid_d = result_valid && result_stall;

		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = CH_NUL;
		mem_raddr = AW'(item.read_index);

		run_user = 1'b0;
		new_seg  = 1'b0;
		dots_n   = dots_q;
		w        = wl_q;
		wl_eff   = wl_q;
		start    = seg_start_q;
		pos      = '0;
		seg_end  = '0;
		c        = item.char_in;

		case (st_q)
			ST_IDLE: begin
				if (accept) begin
					done_d = 1'b0;
					hit_d  = 1'b0;
					st_d   = ST_FIN;
					case (item.mode)
						MODE_CWD: begin
							// A directory byte after the directory ended opens a new job.
							if (ph_q != PH_CWD) begin
								wl_eff      = '0;
								wl_d        = '0;
								seg_len_d   = '0;
								seg_start_d = '0;
								dots_d      = 1'b1;
								err_d       = STAT_OK;
								cwd_trim_d  = '0;
								ph_d        = PH_CWD;
							end
							if (c == CH_NUL) begin
								ph_d = PH_FIRST;
							end else if (wl_eff < LW'(BUF_BYTES)) begin
								mem_we    = 1'b1;
								mem_waddr = wl_eff[AW-1:0];
								mem_wdata = c;
								wl_d      = wl_eff + LW'(1);
								if (wl_eff == '0) begin
									cwd_slash_d = (c == CH_SLASH);
								end
								if (c != CH_SLASH) begin
									cwd_trim_d = wl_eff + LW'(1);
								end
							end
						end
						MODE_USER: begin
							if (ph_q == PH_FIRST) begin
								ph_d = PH_USER;
								if (c == CH_NUL) begin
									if (wl_q >= LW'(BUF_BYTES)) begin
										err_d     = STAT_OVERFLOW;
										wl_d      = '0;
										seg_len_d = '0;
										dots_d    = 1'b1;
									end
									done_d = 1'b1;
									ph_d   = PH_DONE;
								end else if (c == CH_SLASH) begin
									mem_we    = 1'b1;
									mem_waddr = '0;
									mem_wdata = CH_SLASH;
									wl_d      = LW'(1);
								end else if (wl_q == '0 || !cwd_slash_q) begin
									err_d     = STAT_NOT_ABS;
									wl_d      = '0;
									seg_len_d = '0;
									dots_d    = 1'b1;
								end else if (wl_q >= LW'(BUF_BYTES)) begin
									err_d     = STAT_OVERFLOW;
									wl_d      = '0;
									seg_len_d = '0;
									dots_d    = 1'b1;
								end else begin
									// Relative path: start from the directory without its
									// trailing slashes, but keep the root.
									w        = (cwd_trim_q > LW'(1)) ? cwd_trim_q : LW'(1);
									wl_d     = w;
									run_user = 1'b1;
								end
							end else if (ph_q == PH_USER) begin
								run_user = 1'b1;
							end

							if (run_user) begin
								if (err_q != STAT_OK) begin
									if (c == CH_NUL) begin
										done_d = 1'b1;
										ph_d   = PH_DONE;
									end
								end else if (c == CH_NUL || c == CH_SLASH) begin
									seg_len_d = '0;
									dots_d    = 1'b1;
									if (c == CH_NUL) begin
										done_d = 1'b1;
										ph_d   = PH_DONE;
									end
									if (seg_len_q == '0) begin
										// Empty segment from repeated slashes.
									end else if (dots_q && seg_len_q == LW'(1)) begin
										// Current directory: nothing to do.
									end else if (dots_q && seg_len_q == LW'(2)) begin
										// Parent directory: walk back through the buffer.
										if (wl_q > LW'(1)) begin
											st_d = ST_POP_RD;
										end
									end else begin
										seg_end = LW1'(seg_start_q) + LW1'(seg_len_q);
										if (seg_end >= LW1'(BUF_BYTES)) begin
											err_d     = STAT_OVERFLOW;
											wl_d      = '0;
										end else begin
											wl_d = seg_end[LW-1:0];
										end
									end
								end else begin
									new_seg = (seg_len_q == '0);
									if (new_seg) begin
										dots_n = 1'b1;
										if (w > LW'(1)) begin
											start = w + LW'(1);
											if (w < LW'(BUF_BYTES)) begin
												mem_we    = 1'b1;
												mem_waddr = w[AW-1:0];
												mem_wdata = CH_SLASH;
											end
										end else begin
											start = w;
										end
										seg_start_d = start;
										pos         = LW1'(start);
									end else begin
										pos = LW1'(seg_start_q) + LW1'(seg_len_q);
									end
									if (mem_we) begin
										// Separator took the write port; the byte follows.
										pend_we_d   = (pos < LW1'(BUF_BYTES));
										pend_addr_d = pos[AW-1:0];
										pend_char_d = c;
										st_d        = ST_WR2;
									end else if (pos < LW1'(BUF_BYTES)) begin
										mem_we    = 1'b1;
										mem_waddr = pos[AW-1:0];
										mem_wdata = c;
									end
									if (seg_len_q < LW'(BUF_BYTES)) begin
										seg_len_d = seg_len_q + LW'(1);
									end
									dots_d = dots_n && (c == CH_DOT);
								end
							end
						end
						default: begin
							// Read beat; the buffer read is issued at the item's index.
							hit_d = (32'(item.read_index) < 32'(wl_q))
								&& (32'(item.read_index) < 32'(BUF_BYTES));
						end
					endcase
				end
			end
			ST_WR2: begin
				if (pend_we_q) begin
					mem_we    = 1'b1;
					mem_waddr = pend_addr_q;
					mem_wdata = pend_char_q;
				end
				st_d = ST_FIN;
			end
			ST_POP_RD: begin
				mem_raddr = AW'(wl_q - LW'(1));
				st_d      = (wl_q > LW'(1)) ? ST_POP_CHK : ST_FIN;
			end
			ST_POP_CHK: begin
				// Either way the byte goes: a slash ends the walk after removing it.
				wl_d = wl_q - LW'(1);
				st_d = (rdata_q == CH_SLASH) ? ST_FIN : ST_POP_RD;
			end
			ST_FIN: begin
				result_d.done_res   = done_q;
				result_d.status     = err_q;
				result_d.result_len = (32'(wl_q) > RLEN_MAX) ? 12'(RLEN_MAX) : 12'(wl_q);
				result_d.read_char  = hit_q ? rdata_q : CH_NUL;
				result_valid_d      = 1'b1;
				st_d                = ST_IDLE;
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			ph_q         <= PH_CWD;
			wl_q         <= '0;
			seg_len_q    <= '0;
			seg_start_q  <= '0;
			dots_q       <= 1'b1;
			err_q        <= STAT_OK;
			cwd_slash_q  <= 1'b0;
			cwd_trim_q   <= '0;
			done_q       <= 1'b0;
			hit_q        <= 1'b0;
			pend_we_q    <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			st_q         <= st_d;
			ph_q         <= ph_d;
			wl_q         <= wl_d;
			seg_len_q    <= seg_len_d;
			seg_start_q  <= seg_start_d;
			dots_q       <= dots_d;
			err_q        <= err_d;
			cwd_slash_q  <= cwd_slash_d;
			cwd_trim_q   <= cwd_trim_d;
			done_q       <= done_d;
			hit_q        <= hit_d;
			pend_we_q    <= pend_we_d;
			result_valid <= result_valid_d;
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		pend_addr_q <= pend_addr_d;
		pend_char_q <= pend_char_d;
		result      <= result_d;
	end

endmodule

`default_nettype wire
